@@ design/gsw_pkg.sv @@
// Shared types, constants and register codes of the glyph shadow and width block.
package gsw_pkg;

  localparam int CELL_WIDTH = 16;
  localparam int MAX_ROWS   = 64;
  localparam int COL_W      = $clog2(CELL_WIDTH);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int PIX_W      = 8;
  localparam int GW_W       = 5;
  localparam int PAD_W      = 4;
  localparam int CODE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(CELL_WIDTH - 1);
  localparam logic [ROW_W-1:0]  ROW_SAT   = ROW_W'(MAX_ROWS - 1);
  localparam logic [CODE_W-1:0] SPACE_CODE = 8'd32;

  localparam logic [PIX_W-1:0] SHADOW_RST = 8'd32;
  localparam logic [PIX_W-1:0] GLYPH_RST  = 8'd192;
  localparam logic [PIX_W-1:0] CLEAR_RST  = 8'd255;
  localparam logic [GW_W-1:0]  SPACE_RST  = 5'd8;
  localparam logic [PAD_W-1:0] PAD_AMT_RST = 4'd2;
  localparam logic [PAD_W-1:0] PAD_LIM_RST = 4'd14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHADOW_INDEX = 3'd0,
    CFG_GLYPH_INDEX  = 3'd1,
    CFG_CLEAR_INDEX  = 3'd2,
    CFG_SPACE_WIDTH  = 3'd3,
    CFG_PAD_AMOUNT   = 3'd4,
    CFG_PAD_LIMIT    = 3'd5
  } gsw_cfg_idx_t;

  typedef enum logic {
    PH_HELD = 1'b0,
    PH_LAST = 1'b1
  } gsw_phase_t;

  typedef struct packed {
    logic [CELL_WIDTH-1:0] row_bits;
    logic                  last_row;
    logic [CODE_W-1:0]     char_code;
  } gsw_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_index;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [GW_W-1:0]  glyph_width;
    logic             last;
  } gsw_out_t;

  typedef struct packed {
    logic [PIX_W-1:0] shadow_index;
    logic [PIX_W-1:0] glyph_index;
    logic [PIX_W-1:0] clear_index;
    logic [GW_W-1:0]  space_width;
    logic [PAD_W-1:0] pad_amount;
    logic [PAD_W-1:0] pad_limit;
  } gsw_cfg_t;

  // One or two rows ready to be sent pixel by pixel.
  typedef struct packed {
    logic                  has_held;
    logic                  has_last;
    logic [CELL_WIDTH-1:0] glyph_held;
    logic [CELL_WIDTH-1:0] near_held;
    logic [ROW_W-1:0]      idx_held;
    logic [CELL_WIDTH-1:0] glyph_last;
    logic [ROW_W-1:0]      idx_last;
    logic [GW_W-1:0]       width;
  } gsw_job_t;

endpackage

@@ design/glyph_shadow_and_width.sv @@
// Top level of the glyph rasteriser with drop shadow and advance width.
//
// Takes a glyph cell as a stream of 16-pixel rows (column 0 in the top bit) and
// sends out one 8-bit palette pixel per item, column 0 first, one row behind the
// input. A set pixel gets glyph_index; an unset pixel on an inner row whose 3x3
// neighbourhood holds a set pixel gets shadow_index; anything else gets
// clear_index. Pixels outside the cell count as unset. The row flagged last_row
// flushes both the held row and itself, and its final pixel carries last and the
// advance width (space code gets space_width, narrow glyphs get pad_amount added).
// Flow: the first row of a cell yields nothing unless it is also the last row
// (a one-row cell yields 16 pixels); every later row yields 16 pixels and the
// last row of a taller cell 32, sent one per cycle while out_ready is high, by
// the column counter of the output sequencer, which sets the pace. The next row
// is taken in the cycle its predecessor's final pixel enters the output register,
// so a steady stream has no gaps while out_ready stays high. A released row
// waits in the job register and its pixels go out through the output register.
// Configuration is written with cfg_we/cfg_index/cfg_wdata while the block is idle,
// a rule for the user that the block does not enforce; unknown indexes are ignored.
module glyph_shadow_and_width (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input rows
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  gsw_pkg::gsw_in_t                     in_data,
  // output pixels
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output gsw_pkg::gsw_out_t                    out_data,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [gsw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gsw_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import gsw_pkg::*;

  gsw_cfg_t cfg_r, cfg_nxt;
  gsw_job_t job;
  logic     job_load;
  logic     in_fire;

  assign in_fire = in_valid && in_ready;

  // register file: values are masked to each register's width
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (gsw_cfg_idx_t'(cfg_index))
        CFG_SHADOW_INDEX: cfg_nxt.shadow_index = cfg_wdata;
        CFG_GLYPH_INDEX:  cfg_nxt.glyph_index  = cfg_wdata;
        CFG_CLEAR_INDEX:  cfg_nxt.clear_index  = cfg_wdata;
        CFG_SPACE_WIDTH:  cfg_nxt.space_width  = cfg_wdata[GW_W-1:0];
        CFG_PAD_AMOUNT:   cfg_nxt.pad_amount   = cfg_wdata[PAD_W-1:0];
        CFG_PAD_LIMIT:    cfg_nxt.pad_limit    = cfg_wdata[PAD_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shadow_index <= SHADOW_RST;
      cfg_r.glyph_index  <= GLYPH_RST;
      cfg_r.clear_index  <= CLEAR_RST;
      cfg_r.space_width  <= SPACE_RST;
      cfg_r.pad_amount   <= PAD_AMT_RST;
      cfg_r.pad_limit    <= PAD_LIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // row history and job build
  gsw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .job      (job),
    .job_load (job_load)
  );

  // pixel sequencer; its free flag is the input ready
  gsw_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .job_load  (job_load),
    .cfg       (cfg_r),
    .free      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ design/gsw_front.sv @@
// Row history, width tracking and row job build for the glyph shadow block.
module gsw_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  gsw_pkg::gsw_in_t  in_data,
  input  gsw_pkg::gsw_cfg_t cfg,
  output gsw_pkg::gsw_job_t job,
  output logic              job_load
);
  import gsw_pkg::*;

  logic [CELL_WIDTH-1:0] older_r, older_nxt;
  logic [CELL_WIDTH-1:0] middle_r, middle_nxt;
  logic [ROW_W-1:0]      row_count_r, row_count_nxt;
  logic [COL_W-1:0]      widest_r, widest_nxt;

  logic [CELL_WIDTH-1:0] row, vert, near;
  logic [COL_W-1:0]      rmax, widest_new;
  logic [GW_W-1:0]       meas, width;

  always_comb begin
    row  = in_data.row_bits;
    // rightmost set column of the incoming row
    rmax = '0;
    for (int i = 0; i < CELL_WIDTH; i++) begin
      if (row[CELL_WIDTH-1-i]) begin
        rmax = COL_W'(i);
      end
    end
    widest_new = ((row != '0) && (rmax >= widest_r)) ? rmax : widest_r;

    meas = GW_W'(widest_new);
    if (in_data.char_code == SPACE_CODE) begin
      width = cfg.space_width;
    end else if (widest_new <= cfg.pad_limit) begin
      width = meas + GW_W'(cfg.pad_amount);
    end else begin
      width = meas;
    end

    vert = older_r | middle_r | row;
    near = vert | (vert << 1) | (vert >> 1);

    job.has_held   = (row_count_r != '0);
    job.has_last   = in_data.last_row;
    job.glyph_held = middle_r;
    job.near_held  = (row_count_r > ROW_W'(1)) ? near : '0;
    job.idx_held   = row_count_r - ROW_W'(1);
    job.glyph_last = row;
    job.idx_last   = row_count_r;
    job.width      = width;
    job_load       = in_fire && (job.has_held || job.has_last);

    older_nxt     = older_r;
    middle_nxt    = middle_r;
    row_count_nxt = row_count_r;
    widest_nxt    = widest_r;
    if (in_fire) begin
      if (in_data.last_row) begin
        older_nxt     = '0;
        middle_nxt    = '0;
        row_count_nxt = '0;
        widest_nxt    = '0;
      end else begin
        older_nxt     = middle_r;
        middle_nxt    = row;
        widest_nxt    = widest_new;
        if (row_count_r != ROW_SAT) begin
          row_count_nxt = row_count_r + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r     <= '0;
      middle_r    <= '0;
      row_count_r <= '0;
      widest_r    <= '0;
    end else begin
      older_r     <= older_nxt;
      middle_r    <= middle_nxt;
      row_count_r <= row_count_nxt;
      widest_r    <= widest_nxt;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_row |=> row_count_r == '0 && widest_r == '0)
    else $error("cell state not cleared after last row");

  a_first_row_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && row_count_r == '0 && !in_data.last_row |-> !job_load)
    else $error("first row produced a job");
`endif

endmodule

@@ design/gsw_emit.sv @@
// Column sequencer and pixel output register for the glyph shadow block.
module gsw_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  gsw_pkg::gsw_job_t job,
  input  logic              job_load,
  input  gsw_pkg::gsw_cfg_t cfg,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output gsw_pkg::gsw_out_t out_data
);
  import gsw_pkg::*;

  gsw_job_t   job_r, job_nxt;
  logic       job_valid_r, job_valid_nxt;
  gsw_phase_t phase_r, phase_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic       out_valid_r, out_valid_nxt;
  gsw_out_t   out_data_r, out_data_nxt;

  logic adv, col_end, job_end;
  logic [COL_W-1:0] bit_idx;
  logic g_bit, n_bit;
  gsw_out_t pix;

  always_comb begin
    adv     = job_valid_r && (!out_valid_r || out_ready);
    col_end = (col_r == COL_LAST);
    job_end = col_end && ((phase_r == PH_LAST) || !job_r.has_last);
    free    = !job_valid_r || (adv && job_end);

    bit_idx = COL_LAST - col_r;
    if (phase_r == PH_LAST) begin
      g_bit = job_r.glyph_last[bit_idx];
      n_bit = 1'b0;
      pix.row = job_r.idx_last;
    end else begin
      g_bit = job_r.glyph_held[bit_idx];
      n_bit = job_r.near_held[bit_idx];
      pix.row = job_r.idx_held;
    end
    pix.pixel_index = g_bit ? cfg.glyph_index : (n_bit ? cfg.shadow_index : cfg.clear_index);
    pix.column      = col_r;
    pix.last        = col_end && (phase_r == PH_LAST);
    pix.glyph_width = pix.last ? job_r.width : '0;

    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    phase_nxt     = phase_r;
    col_nxt       = col_r;
    if (job_load) begin
      job_nxt       = job;
      job_valid_nxt = 1'b1;
      phase_nxt     = job.has_held ? PH_HELD : PH_LAST;
      col_nxt       = '0;
    end else if (adv) begin
      if (col_end) begin
        col_nxt = '0;
        if (job_end) begin
          job_valid_nxt = 1'b0;
        end else begin
          phase_nxt = PH_LAST;
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = pix;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      phase_r     <= PH_HELD;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      phase_r     <= phase_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_last_on_final_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.column == COL_LAST)
    else $error("last flag away from final column");

  a_width_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.glyph_width == '0)
    else $error("width reported on a non-final pixel");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the glyph rasteriser with drop shadow and advance width.
module tb_top;
  import gsw_pkg::*;

  // Timing knobs
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 8;     // quiet time once the last pixel is out
  localparam int STALL_LIMIT   = 5000;  // cycles with no item moving on either side
  localparam int GLYPH_ROWS    = 8;     // most rows a directed glyph carries

  // Register slots the block does not implement
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;
  typedef enum int {INK_DENSE, INK_SPARSE, INK_SINGLE, INK_BLANK} ink_style_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  gsw_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  gsw_out_t out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  glyph_shadow_and_width dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin : clock_gen
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Rasteriser predictor: own copy of the registers and of the row history.
  // ---------------------------------------------------------------------------
  gsw_cfg_t regs = '{shadow_index: SHADOW_RST, glyph_index: GLYPH_RST,
                     clear_index: CLEAR_RST, space_width: SPACE_RST,
                     pad_amount: PAD_AMT_RST, pad_limit: PAD_LIM_RST};

  logic [CELL_WIDTH-1:0] older_bits  = '0;  // two rows back
  logic [CELL_WIDTH-1:0] held_bits   = '0;  // row waiting to be drawn
  logic [ROW_W-1:0]      next_row    = '0;  // index of the next incoming row
  logic [COL_W-1:0]      rightmost   = '0;  // rightmost inked column so far
  logic                  ink_seen    = 1'b0;

  gsw_out_t pending_pixels [$];  // pixels still owed by the block, oldest first
  int       errors = 0;

  // Draw one row: glyph where inked, shadow where a 3x3 neighbour is inked (inner
  // rows only), clear elsewhere. Neighbours off the cell edge are blank.
  function automatic void draw_row(input logic [CELL_WIDTH-1:0] above,
                                   input logic [CELL_WIDTH-1:0] mid,
                                   input logic [CELL_WIDTH-1:0] below,
                                   input logic shadow_ok, input logic [ROW_W-1:0] row_idx,
                                   input logic ends_cell, input logic [GW_W-1:0] width);
    logic [CELL_WIDTH-1:0] vert;
    logic [CELL_WIDTH-1:0] halo;
    gsw_out_t px;
    vert = above | mid | below;
    halo = vert | (vert << 1) | (vert >> 1);
    for (int col = 0; col < CELL_WIDTH; col++) begin
      if (mid[CELL_WIDTH-1-col])
        px.pixel_index = regs.glyph_index;
      else if (shadow_ok && halo[CELL_WIDTH-1-col])
        px.pixel_index = regs.shadow_index;
      else
        px.pixel_index = regs.clear_index;
      px.column      = COL_W'(col);
      px.row         = row_idx;
      px.last        = ends_cell && (col == CELL_WIDTH - 1);
      px.glyph_width = px.last ? width : '0;
      pending_pixels.push_back(px);
    end
  endfunction

  // Called once per accepted row: queues the pixels that row releases.
  function automatic void rasterise_row(input gsw_in_t item);
    logic [ROW_W-1:0] cur;
    int adv;
    cur = next_row;
    for (int col = 0; col < CELL_WIDTH; col++)
      if (item.row_bits[CELL_WIDTH-1-col] && col >= int'(rightmost)) begin
        rightmost = COL_W'(col);
        ink_seen  = 1'b1;
      end
    // held row drawn with the new row below it; shadow off on the cell's top row
    if (cur != '0)
      draw_row(older_bits, held_bits, item.row_bits, cur != ROW_W'(1), cur - ROW_W'(1),
               1'b0, '0);
    if (item.last_row) begin
      adv = ink_seen ? int'(rightmost) : 0;
      if (item.char_code == SPACE_CODE)
        adv = int'(regs.space_width);
      else if (adv <= int'(regs.pad_limit))
        adv += int'(regs.pad_amount);
      draw_row(held_bits, item.row_bits, '0, 1'b0, cur, 1'b1, GW_W'(adv));
      older_bits = '0;
      held_bits  = '0;
      next_row   = '0;
      rightmost  = '0;
      ink_seen   = 1'b0;
    end else begin
      older_bits = held_bits;
      held_bits  = item.row_bits;
      if (next_row != ROW_SAT)
        next_row = next_row + ROW_W'(1);  // saturates at the top row index
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel checker: every accepted pixel against the oldest one owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_pixel
    gsw_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel with nothing owed: row %0d column %0d", out_data.row, out_data.column);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.pixel_index !== want.pixel_index) begin
          $error("pixel_index: expected %0d, got %0d", want.pixel_index, out_data.pixel_index);
          errors++;
        end
        if (out_data.column !== want.column) begin
          $error("column: expected %0d, got %0d", want.column, out_data.column);
          errors++;
        end
        if (out_data.row !== want.row) begin
          $error("row: expected %0d, got %0d", want.row, out_data.row);
          errors++;
        end
        if (out_data.glyph_width !== want.glyph_width) begin
          $error("glyph_width: expected %0d, got %0d", want.glyph_width, out_data.glyph_width);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long with no item moving on either channel ends the run.
  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: picks open, random or fixed-pattern stretches at random; on request it
  // holds ready low for a long stretch so the block backs up into its input.
  // ---------------------------------------------------------------------------
  logic hold_off_req = 1'b0;

  initial begin : receiver
    rx_mode_t mode;
    int span;
    int tick;
    tick = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 2));
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(posedge clk);
        if (hold_off_req) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_off_req = 1'b0;
        end
        tick++;
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_RANDOM: out_ready <= ($urandom_range(0, 99) < 60);
          default:   out_ready <= (tick % 5 != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  logic steady_feed = 1'b0;  // no gaps between rows while set
  int   burst_left  = 0;

  function automatic gsw_in_t row_item(input logic [CELL_WIDTH-1:0] bits,
                                       input logic last, input logic [CODE_W-1:0] code);
    gsw_in_t item;
    item.row_bits  = bits;
    item.last_row  = last;
    item.char_code = code;
    return item;
  endfunction

  // Offers one row and returns at the edge that accepts it. Valid is left high so
  // a following row can go straight out; settle() drops it.
  task automatic send_row(input gsw_in_t item);
    int gap;
    if (!steady_feed) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 40);
        burst_left = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rasterise_row(item);
  endtask

  // Rows packed top row first in the upper slices of bits.
  task automatic send_glyph(input int rows, input logic [GLYPH_ROWS*CELL_WIDTH-1:0] bits,
                            input logic [CODE_W-1:0] code);
    for (int r = 0; r < rows; r++)
      send_row(row_item(bits[(rows-1-r)*CELL_WIDTH +: CELL_WIDTH], r == rows - 1,
                        (r == rows - 1) ? code : CODE_W'($urandom)));
  endtask

  function automatic logic [CELL_WIDTH-1:0] random_row(input ink_style_t style);
    case (style)
      INK_DENSE:  return CELL_WIDTH'($urandom);
      INK_SPARSE: return CELL_WIDTH'($urandom & $urandom & $urandom);
      INK_SINGLE: return ($urandom_range(0, 2) == 0) ? '0
                         : CELL_WIDTH'(1) << $urandom_range(0, CELL_WIDTH - 1);
      default:    return ($urandom_range(0, 7) == 0) ? CELL_WIDTH'($urandom) : '0;
    endcase
  endfunction

  task automatic send_cell(input int rows);
    ink_style_t style;
    logic [CODE_W-1:0] code;
    style = ink_style_t'($urandom_range(0, 3));
    code  = ($urandom_range(0, 4) == 0) ? SPACE_CODE : CODE_W'($urandom);
    for (int r = 0; r < rows; r++)
      send_row(row_item(random_row(style), r == rows - 1,
                        (r == rows - 1) ? code : CODE_W'($urandom)));
  endtask

  // Stop offering, let every owed pixel drain, then leave the block quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write per edge; cfg_done() drops the enable after a batch.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_SHADOW_INDEX: regs.shadow_index = data;
      CFG_GLYPH_INDEX:  regs.glyph_index  = data;
      CFG_CLEAR_INDEX:  regs.clear_index  = data;
      CFG_SPACE_WIDTH:  regs.space_width  = data[GW_W-1:0];
      CFG_PAD_AMOUNT:   regs.pad_amount   = data[PAD_W-1:0];
      CFG_PAD_LIMIT:    regs.pad_limit    = data[PAD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
  endtask

  task automatic load_registers(input logic [CFG_DATA_W-1:0] shadow, glyph, clear,
                                input logic [CFG_DATA_W-1:0] space, pad, limit);
    cfg_write(CFG_SHADOW_INDEX, shadow);
    cfg_write(CFG_GLYPH_INDEX, glyph);
    cfg_write(CFG_CLEAR_INDEX, clear);
    cfg_write(CFG_SPACE_WIDTH, space);
    cfg_write(CFG_PAD_AMOUNT, pad);
    cfg_write(CFG_PAD_LIMIT, limit);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values: one-row cells, shadow on inner rows only, edge
  // columns (outside neighbours blank), space width, padding either side of the
  // limit.
  task automatic test_reset_values();
    send_glyph(1, 16'hFFFF, 8'h41);                              // full row, wide
    send_glyph(1, 16'h0000, 8'h00);                              // blank, padded
    send_glyph(3, {16'h0000, 16'h0100, 16'h0000}, 8'hFF);        // lone dot
    send_glyph(4, {16'h8000, 16'h0001, 16'h8001, 16'h0000}, SPACE_CODE);
    send_glyph(2, {16'hFFFF, 16'hFFFF}, 8'h7F);                  // two-row, no inner
    send_glyph(3, {16'h0000, 16'h0000, 16'h0002}, 8'h80);        // width at pad limit
    send_glyph(5, {16'h0000, 16'h0001, 16'h0000, 16'h4000, 16'h0000}, 8'h01);
    settle();
  endtask

  // Registers at both ends of their ranges, then values wider than the register
  // and writes to the unused slots.
  task automatic test_register_extremes();
    load_registers(8'd0, 8'd255, 8'd0, 8'd0, 8'd15, 8'd15);
    cfg_done();
    send_glyph(3, {16'h0000, 16'h0180, 16'h0000}, 8'h42);
    send_glyph(1, 16'h0000, SPACE_CODE);                          // space width zero
    send_glyph(1, 16'h0000, 8'h43);                               // 0 + 15
    send_glyph(1, 16'hFFFF, 8'h44);                               // 15 + 15
    settle();
    load_registers(8'd255, 8'd0, 8'h80, 8'd16, 8'd0, 8'd0);
    cfg_done();
    send_glyph(1, 16'h0000, SPACE_CODE);                          // space width 16
    send_glyph(3, {16'h8000, 16'hC000, 16'h8000}, 8'h45);         // left edge columns
    send_glyph(2, {16'h0000, 16'h0010}, 8'hFE);
    settle();
    load_registers(8'hA5, 8'h5A, 8'h3C, 8'hFF, 8'hF7, 8'hFA);   // upper bits dropped
    cfg_write(CFG_SPARE_LO, 8'h00);
    cfg_write(CFG_SPARE_HI, 8'hFF);
    cfg_done();
    send_glyph(1, 16'h1234, SPACE_CODE);
    send_glyph(2, {16'h0020, 16'h0000}, 8'h46);                   // col 10: padded
    send_glyph(2, {16'h0000, 16'h0010}, 8'h47);                   // col 11: not
    settle();
  endtask

  // A cell taller than the row counter, so the row index sticks at the top.
  task automatic test_tall_cell();
    send_cell(MAX_ROWS + 6);
    settle();
  endtask

  // Receiver holds off while rows keep coming, so the block backs up.
  task automatic test_output_backpressure();
    hold_off_req = 1'b1;
    steady_feed  = 1'b1;
    for (int c = 0; c < 3; c++)
      send_cell(6);
    steady_feed = 1'b0;
    settle();
  endtask

  // Random cells under a fresh register setting per phase; one phase unthrottled.
  task automatic test_random_cells();
    int sent;
    int rows;
    for (int ph = 0; ph < 4; ph++) begin
      load_registers(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                     ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                                 : CFG_DATA_W'($urandom_range(0, 16)),
                     CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 15)));
      cfg_done();
      steady_feed = (ph == 2);
      sent = 0;
      while (sent < 30) begin
        rows = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        send_cell(rows);
        sent += rows;
      end
      steady_feed = 1'b0;
      settle();
    end
  endtask

  initial begin : run
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_register_extremes();
    test_tall_cell();
    test_output_backpressure();
    test_random_cells();
    settle();
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
design/gsw_pkg.sv
design/gsw_front.sv
design/gsw_emit.sv
design/glyph_shadow_and_width.sv
tb/tb_top.sv
